// ----- src/cbe_pkg.sv -----
// Shared types, constants and the rounded fixed-point product for the
// cubic-bezier easing evaluator. No dependencies.
package cbe_pkg;

  localparam int FRAC_BITS = 15;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int MW        = 24;   // datapath word for products and sums
  localparam int NUM_W     = 40;   // (x - t) scaled by ONE
  localparam int DEN_W     = MW;   // derivative magnitude
  localparam int QW        = 17;   // quotient bits; larger quotients saturate
  localparam int SW        = 20;   // width for the s update
  localparam int OUT_W     = 18;
  localparam int OUT_MAX   = 131071;
  localparam int OUT_MIN   = -131072;
  localparam int CFG_W     = 18;

  localparam logic [1:0] REG_X1 = 2'd0;
  localparam logic [1:0] REG_Y1 = 2'd1;
  localparam logic [1:0] REG_X2 = 2'd2;
  localparam logic [1:0] REG_Y2 = 2'd3;

  typedef logic signed [MW-1:0] fx_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             sat;
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    low;
    logic [QW-1:0]    quo;
    logic [DEN_W-1:0] den;
  } div_stage_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_UU, ST_US, ST_SS, ST_B1, ST_B2, ST_B3,
    ST_X1, ST_X2, ST_XC, ST_D1, ST_D2, ST_D3, ST_DIV, ST_DWAIT,
    ST_Y1, ST_Y2, ST_YF, ST_DONE
  } state_t;

  // Product rounded to FRAC_BITS fraction bits, halves away from zero.
  function automatic fx_t mulq(fx_t a, fx_t b);
    logic            neg;
    logic [MW-1:0]   ma;
    logic [MW-1:0]   mb;
    logic [2*MW-1:0] p;
    logic [MW-1:0]   r;
    neg = a[MW-1] ^ b[MW-1];
    ma  = a[MW-1] ? MW'(-a) : MW'(a);
    mb  = b[MW-1] ? MW'(-b) : MW'(b);
    p   = (2*MW)'(ma) * (2*MW)'(mb);
    p   = p + ((2*MW)'(1) << (FRAC_BITS - 1));
    r   = MW'(p >> FRAC_BITS);
    return neg ? fx_t'(-r) : fx_t'(r);
  endfunction

endpackage

// ----- src/cbe_div_cell.sv -----
// One cell of the divider chain: one restoring quotient bit per cycle.
// Depends on cbe_pkg.
module cbe_div_cell import cbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  div_stage_t din,
  output div_stage_t dout
);

  logic [DEN_W:0] r2;
  logic [DEN_W:0] diff;
  logic           ge;

  always_comb begin
    r2   = {din.rem, din.low[QW-1]};
    ge   = r2 >= {1'b0, din.den};
    diff = r2 - {1'b0, din.den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.neg <= din.neg;
    dout.sat <= din.sat;
    dout.den <= din.den;
    dout.rem <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
    dout.low <= din.low << 1;
    dout.quo <= {din.quo[QW-2:0], ge};
  end

endmodule

// ----- src/cbe_divider.sv -----
// Signed divider, quotient truncated toward zero, built as a chain of cells.
// Depends on cbe_pkg and cbe_div_cell.
module cbe_divider import cbe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [QW+1:0]    quo
);

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic             sat;
  logic [QW:0]      q_mag;
  div_stage_t       chain [QW+1];

  always_comb begin
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    // quotient of 2^QW or more pushes s out of [0, ONE] anyway
    sat     = {1'b0, num_mag} >= {den_mag, {QW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= start;
    end
    chain[0].neg <= num[NUM_W-1] ^ den[DEN_W-1];
    chain[0].sat <= sat;
    chain[0].rem <= DEN_W'(num_mag >> QW);
    chain[0].low <= num_mag[QW-1:0];
    chain[0].quo <= '0;
    chain[0].den <= den_mag;
  end

  for (genvar i = 0; i < QW; i++) begin : g_cell
    cbe_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  always_comb begin
    done  = chain[QW].valid;
    q_mag = chain[QW].sat ? ((QW+1)'(1) << QW) : {1'b0, chain[QW].quo};
    quo   = chain[QW].neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

endmodule

// ----- src/cubic_bezier_easing_eval_top.sv -----
// Cubic-bezier easing evaluator: Newton solve of x(s)=t, then y(s).
// For progress at 0, at or above 1.0, or a linear curve the result goes straight to
// the output; otherwise each Newton step runs the products, sums and checks, starts
// the divider and waits on the divider chain, and after at most MAX_STEPS steps
// y(s) is formed and output. One item at a time: the next item is accepted the
// cycle after the result is loaded. Synchronous active-high reset loads default controls.
module cubic_bezier_easing_eval_top import cbe_pkg::*; #(
  parameter int MAX_STEPS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [15:0]             progress,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] eased,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int  IW    = $clog2(MAX_STEPS + 1);
  localparam fx_t ONE_F = fx_t'(ONE_Q);

  state_t state, state_next;

  logic [15:0]             x1, x2, t, s;
  logic signed [17:0]      y1, y2;
  fx_t                     uu, us, ss, b1, b2, b3, acc, xv, dx;
  logic [IW-1:0]           iter;
  logic                    fin;
  logic signed [OUT_W-1:0] res;

  fx_t x1f, x2f, y1f, y2f, sf, tf, uf, ma, mb, prod, sum_b3, dsum;
  logic                    accept, load_out, div_start, div_done;
  logic signed [NUM_W-1:0] num;
  logic signed [QW+1:0]    div_q;
  logic signed [SW-1:0]    s_new;
  logic [15:0]             s_clamp;

  always_comb begin
    x1f    = fx_t'($signed({1'b0, x1}));
    x2f    = fx_t'($signed({1'b0, x2}));
    y1f    = fx_t'(y1);
    y2f    = fx_t'(y2);
    sf     = fx_t'($signed({1'b0, s}));
    tf     = fx_t'($signed({1'b0, t}));
    uf     = ONE_F - sf;
    in_stall  = state != ST_IDLE;
    accept    = in_valid && !in_stall;
    load_out  = state == ST_DONE && (!out_valid || !out_stall);
    div_start = state == ST_DIV;
    num       = NUM_W'(xv - tf) <<< FRAC_BITS;
    sum_b3    = acc + b3;
    dsum      = dx + fx_t'(3) * prod;
    s_new     = SW'($signed({1'b0, s})) - SW'(div_q);
    if (s_new < 0) begin
      s_clamp = '0;
    end else if (s_new > SW'(ONE_Q)) begin
      s_clamp = 16'(ONE_Q);
    end else begin
      s_clamp = s_new[15:0];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_UU: begin ma = uf; mb = uf; end
      ST_US: begin ma = uf; mb = sf; end
      ST_SS: begin ma = sf; mb = sf; end
      ST_B1: begin ma = uu; mb = sf; end
      ST_B2: begin ma = us; mb = sf; end
      ST_B3: begin ma = ss; mb = sf; end
      ST_X1: begin ma = b1; mb = x1f; end
      ST_X2: begin ma = b2; mb = x2f; end
      ST_D1: begin ma = uu; mb = x1f; end
      ST_D2: begin ma = us; mb = x2f - x1f; end
      ST_D3: begin ma = ss; mb = ONE_F - x2f; end
      ST_Y1: begin ma = b1; mb = y1f; end
      ST_Y2: begin ma = b2; mb = y2f; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = mulq(ma, mb);
  end

  cbe_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (dx),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (progress == 16'd0 || progress >= 16'(ONE_Q) ||
              (x1f == y1f && x2f == y2f)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_UU;
          end
        end
      end
      ST_UU:  state_next = ST_US;
      ST_US:  state_next = ST_SS;
      ST_SS:  state_next = ST_B1;
      ST_B1:  state_next = ST_B2;
      ST_B2:  state_next = ST_B3;
      ST_B3:  state_next = fin ? ST_Y1 : ST_X1;
      ST_X1:  state_next = ST_X2;
      ST_X2:  state_next = ST_XC;
      ST_XC:  state_next = (sum_b3 == tf) ? ST_Y1 : ST_D1;
      ST_D1:  state_next = ST_D2;
      ST_D2:  state_next = ST_D3;
      ST_D3:  state_next = (dsum == '0) ? ST_Y1 : ST_DIV;
      ST_DIV: state_next = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_next = ST_UU;
        end
      end
      ST_Y1:  state_next = ST_Y2;
      ST_Y2:  state_next = ST_YF;
      ST_YF:  state_next = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers and item bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      x1        <= 16'd8192;
      y1        <= 18'sd3277;
      x2        <= 16'd8192;
      y2        <= 18'sd32768;
      out_valid <= 1'b0;
      fin       <= 1'b0;
      iter      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_X1:  x1 <= cfg_data[15:0];
          REG_Y1:  y1 <= $signed(cfg_data);
          REG_X2:  x2 <= cfg_data[15:0];
          REG_Y2:  y2 <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        fin  <= 1'b0;
        iter <= '0;
      end else if (state == ST_DWAIT && div_done) begin
        iter <= iter + 1'b1;
        if (iter + 1'b1 == IW'(MAX_STEPS)) begin
          fin <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      eased <= res;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          t <= progress;
          s <= progress;
          if (progress == 16'd0) begin
            res <= '0;
          end else if (progress >= 16'(ONE_Q)) begin
            res <= OUT_W'(ONE_Q);
          end else begin
            res <= OUT_W'($signed({1'b0, progress}));
          end
        end
      end
      ST_UU:    uu  <= prod;
      ST_US:    us  <= prod;
      ST_SS:    ss  <= prod;
      ST_B1:    b1  <= fx_t'(3) * prod;
      ST_B2:    b2  <= fx_t'(3) * prod;
      ST_B3:    b3  <= prod;
      ST_X1:    acc <= prod;
      ST_X2:    acc <= acc + prod;
      ST_XC:    xv  <= sum_b3;
      ST_D1:    dx  <= fx_t'(3) * prod;
      ST_D2:    dx  <= dx + fx_t'(6) * prod;
      ST_D3:    dx  <= dsum;
      ST_DWAIT: begin
        if (div_done) begin
          s <= s_clamp;
        end
      end
      ST_Y1:    acc <= prod;
      ST_Y2:    acc <= acc + prod;
      ST_YF: begin
        if (sum_b3 > fx_t'(OUT_MAX)) begin
          res <= OUT_W'(OUT_MAX);
        end else if (sum_b3 < fx_t'(OUT_MIN)) begin
          res <= OUT_W'(OUT_MIN);
        end else begin
          res <= sum_b3[OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sim/tb_cubic_bezier_easing_eval_top.sv -----
// Testbench for the cubic-bezier easing evaluator: random and directed progress
// items, checked against a fixed-point predictor kept in a small scoreboard class.
// Depends on cbe_pkg and cubic_bezier_easing_eval_top.
module tb_cubic_bezier_easing_eval_top import cbe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEWTON_STEPS = 8;
  localparam int STALL_LIMIT  = 3000;

  class easing_scoreboard;
    longint          x1, x2, y1, y2;
    logic [OUT_W-1:0] expected_eased[$];
    int              failures;

    function new();
      x1 = 8192; y1 = 3277; x2 = 8192; y2 = 32768;
      failures = 0;
    endfunction

    function void set_controls(logic [15:0] cx1, logic signed [17:0] cy1,
                               logic [15:0] cx2, logic signed [17:0] cy2);
      x1 = cx1; y1 = cy1; x2 = cx2; y2 = cy2;
    endfunction

    // Rounded product, halves away from zero.
    function longint rmul(longint a, longint b);
      longint ma, mb, r;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      r = (ma * mb + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function longint curve(longint s, longint p1, longint p2);
      longint u, uu, us, ss;
      u  = ONE_Q - s;
      uu = rmul(u, u);
      us = rmul(u, s);
      ss = rmul(s, s);
      return rmul(3 * rmul(uu, s), p1) + rmul(3 * rmul(us, s), p2) + rmul(ss, s);
    endfunction

    function logic [OUT_W-1:0] ease(logic [15:0] progress);
      longint t, s, x, dx, u, uu, us, ss, y;
      t = progress;
      if (t == 0) return '0;
      if (t >= ONE_Q) return OUT_W'(ONE_Q);
      if (x1 == y1 && x2 == y2) return OUT_W'(t);
      s = t;
      for (int i = 0; i < NEWTON_STEPS; i++) begin
        x = curve(s, x1, x2);
        if (x == t) break;
        u  = ONE_Q - s;
        uu = rmul(u, u);
        us = rmul(u, s);
        ss = rmul(s, s);
        dx = 3 * rmul(uu, x1) + 6 * rmul(us, x2 - x1) + 3 * rmul(ss, ONE_Q - x2);
        if (dx == 0) break;
        s = s - ((x - t) * ONE_Q) / dx;
        if (s < 0) s = 0;
        if (s > ONE_Q) s = ONE_Q;
      end
      y = curve(s, y1, y2);
      if (y > OUT_MAX) y = OUT_MAX;
      if (y < OUT_MIN) y = OUT_MIN;
      return OUT_W'(y);
    endfunction

    function void note_progress(logic [15:0] progress);
      expected_eased.insert(expected_eased.size(), ease(progress));
    endfunction

    function void check_eased(logic [OUT_W-1:0] eased);
      logic [OUT_W-1:0] want;
      if (expected_eased.size() == 0) begin
        $error("eased: unexpected item, actual %0d", $signed(eased));
        failures++;
        return;
      end
      want = expected_eased.pop_front();
      if (want !== eased) begin
        $error("eased: expected %0d, actual %0d", $signed(want), $signed(eased));
        failures++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [15:0]        progress = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [OUT_W-1:0]   eased;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = REG_X1;
  logic [CFG_W-1:0]   cfg_data = '0;

  easing_scoreboard sb = new();
  bit   idling = 1;
  int   quiet_cycles = 0;

  cubic_bezier_easing_eval_top i_dut (
    .clk, .rst, .in_valid, .in_stall, .progress,
    .out_valid, .out_stall, .eased,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  // Check results and watch for a hang.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_eased(eased);
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: while idling is set, hold stall for a random count of cycles per item.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = idling ? $urandom_range(0, 19) : 0;
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_progress(logic [15:0] value);
    int gap;
    gap = idling ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    progress <= value;
    do @(posedge clk); while (in_stall);
    sb.note_progress(value);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_eased.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_controls(logic [15:0] cx1, logic signed [17:0] cy1,
                                  logic [15:0] cx2, logic signed [17:0] cy2);
    cfg_we <= 1;
    cfg_index <= REG_X1; cfg_data <= CFG_W'(cx1); @(posedge clk);
    cfg_index <= REG_Y1; cfg_data <= cy1;         @(posedge clk);
    cfg_index <= REG_X2; cfg_data <= CFG_W'(cx2); @(posedge clk);
    cfg_index <= REG_Y2; cfg_data <= cy2;         @(posedge clk);
    cfg_we <= 0;
    sb.set_controls(cx1, cy1, cx2, cy2);
  endtask

  task automatic run_phase();
    logic [15:0] corners[12] = '{16'd0, 16'd1, 16'd2, 16'd16384, 16'd32766, 16'd32767,
                                 16'd32768, 16'd32769, 16'd65535, 16'h5555,
                                 16'h2AAA, 16'd100};
    int pick;
    logic [15:0] v;
    foreach (corners[i]) send_progress(corners[i]);
    for (int i = 0; i < 95; i++) begin
      if (i % 40 == 20) idling = 0;
      if (i % 40 == 35) idling = 1;
      pick = $urandom_range(0, 9);
      if (pick < 8)       v = 16'($urandom_range(0, 32768));
      else if (pick == 8) v = $urandom_range(0, 1) ? 16'($urandom_range(0, 40))
                                                  : 16'($urandom_range(32700, 32768));
      else                v = 16'($urandom);
      send_progress(v);
    end
    idling = 1;
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    run_phase();                                     // reset controls
    program_controls(16'd13763, 18'sd0, 16'd19005, 18'sd32768);
    run_phase();
    program_controls(16'd9830, 18'sd9830, 16'd52000, 18'sd52000);   // linear
    run_phase();
    program_controls(16'd0, -18'sd131072, 16'd65535, 18'sd131071);
    run_phase();
    program_controls(16'd65535, 18'sd131071, 16'd0, -18'sd131072);
    run_phase();
    program_controls(16'd32768, -18'sd1, 16'd32768, 18'sd0);
    run_phase();
    program_controls(16'($urandom_range(0, 32768)), 18'($urandom_range(0, 65535) - 32768),
                     16'($urandom_range(0, 32768)), 18'($urandom_range(0, 131071) - 32768));
    run_phase();
    repeat (300) @(posedge clk);
    if (sb.failures == 0 && sb.expected_eased.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/cbe_pkg.sv
src/cbe_div_cell.sv
src/cbe_divider.sv
src/cubic_bezier_easing_eval_top.sv
sim/tb_cubic_bezier_easing_eval_top.sv
